// ===== hw/rtl/prt_pkg.sv =====
// Shared types and constants for the page reference count table.
// Used by the controller, the datapath and the top level; no dependencies.
package prt_pkg;

   localparam int TABLE_ENTRIES_DEF   = 256;
   localparam int PAGE_SHIFT_BITS_DEF = 12;
   localparam int ADDR_BITS_DEF       = 52;

   localparam int FUNC_W       = 2;
   localparam int STATUS_W     = 3;
   localparam int COUNT_W      = 16;
   localparam int LIVE_OUT_W   = 9;
   localparam int STAT_W       = 32;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 16;

   localparam int SCAN_GROUP    = 16;
   localparam int SCAN_LOC_BITS = $clog2(SCAN_GROUP);

   localparam logic [COUNT_W-1:0] MAX_REFCOUNT_RESET = 16'hFFFF;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ADD = 2'd0,
      FUNC_INC = 2'd1,
      FUNC_DEC = 2'd2,
      FUNC_GET = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 3'd0,
      ST_NOT_INIT    = 3'd1,
      ST_NOT_TRACKED = 3'd2,
      ST_MAX_REF     = 3'd3,
      ST_FULL        = 3'd4
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ENABLED      = 1'd0,
      CSR_MAX_REFCOUNT = 1'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_SCAN   = 2'd1,
      S_SELECT = 2'd2,
      S_UPDATE = 2'd3
   } state_type;

   typedef struct packed {
      logic accept;
      logic scan;
      logic select;
      logic update;
   } cmd_type;

   typedef struct packed {
      logic out_ready;
   } sts_type;

endpackage

// ===== hw/rtl/prt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module prt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/prt_ctrl.sv =====
// Sequencing state machine for the page reference count table.
// Depends on prt_pkg for state, command and status types.
module prt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  prt_pkg::sts_type sts,
   output prt_pkg::cmd_type cmd
);
   import prt_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN:   state_in = S_SELECT;
         S_SELECT: state_in = S_UPDATE;
         S_UPDATE: begin
            if (sts.out_ready) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         S_SCAN:   cmd.scan   = 1'b1;
         S_SELECT: cmd.select = 1'b1;
         S_UPDATE: cmd.update = sts.out_ready;
         default:  cmd        = '0;
      endcase
   end

endmodule

// ===== hw/rtl/prt_datapath.sv =====
// Datapath: tracked-page table, two-level match and free-slot scan, count RAM,
// statistics, configuration registers and result register. Uses prt_pkg, prt_ram.
module prt_datapath #(
   parameter int TABLE_ENTRIES   = prt_pkg::TABLE_ENTRIES_DEF,
   parameter int PAGE_SHIFT_BITS = prt_pkg::PAGE_SHIFT_BITS_DEF,
   parameter int ADDR_BITS       = prt_pkg::ADDR_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  prt_pkg::cmd_type                cmd,
   output prt_pkg::sts_type                sts,
   input  logic [prt_pkg::FUNC_W-1:0]      req_func,
   input  logic [ADDR_BITS-1:0]            req_phys_addr,
   input  logic                            csr_wr_en,
   input  logic [prt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [prt_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [prt_pkg::STATUS_W-1:0]    rsp_status,
   output logic [prt_pkg::COUNT_W-1:0]     rsp_ref_count,
   output logic [prt_pkg::LIVE_OUT_W-1:0]  rsp_live_entries,
   output logic [prt_pkg::STAT_W-1:0]      rsp_total_added,
   output logic [prt_pkg::STAT_W-1:0]      rsp_total_freed
);
   import prt_pkg::*;

   localparam int PAGE_W = ADDR_BITS - PAGE_SHIFT_BITS;
   localparam int IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int NGROUP = (TABLE_ENTRIES + SCAN_GROUP - 1) / SCAN_GROUP;
   localparam int GRP_W  = (NGROUP > 1) ? $clog2(NGROUP) : 1;
   localparam int PAD_N  = NGROUP * SCAN_GROUP;
   localparam int LIVE_W = $clog2(TABLE_ENTRIES + 1);

   function automatic logic [SCAN_LOC_BITS-1:0] lowest_loc(input logic [SCAN_GROUP-1:0] v);
      logic [SCAN_GROUP-1:0]    one;
      logic [SCAN_LOC_BITS-1:0] idx;
      one = v & (~v + 1'b1);
      idx = '0;
      for (int i = 0; i < SCAN_GROUP; i++) begin
         if (one[i]) begin
            idx = idx | SCAN_LOC_BITS'(i);
         end
      end
      return idx;
   endfunction

   func_type                 func_ff;
   logic [PAGE_W-1:0]        page_ff;
   logic                     enabled_ff;
   logic [COUNT_W-1:0]       max_ff;
   logic [TABLE_ENTRIES-1:0] entry_valid_ff;
   logic [TABLE_ENTRIES-1:0] entry_valid_in;
   logic [PAGE_W-1:0]        entry_page_ff [TABLE_ENTRIES];
   logic [NGROUP-1:0]        hit_grp_any_ff;
   logic [NGROUP-1:0]        free_grp_any_ff;
   logic [SCAN_LOC_BITS-1:0] hit_grp_loc_ff  [NGROUP];
   logic [SCAN_LOC_BITS-1:0] free_grp_loc_ff [NGROUP];
   logic                     hit_ff;
   logic                     free_any_ff;
   logic [IDX_W-1:0]         slot_ff;
   logic [LIVE_W-1:0]        live_ff;
   logic [LIVE_W-1:0]        live_in;
   logic [STAT_W-1:0]        added_ff;
   logic [STAT_W-1:0]        added_in;
   logic [STAT_W-1:0]        freed_ff;
   logic [STAT_W-1:0]        freed_in;
   logic                     rsp_valid_ff;
   status_type               rsp_status_ff;
   status_type               status_in;
   logic [COUNT_W-1:0]       rsp_count_ff;
   logic [COUNT_W-1:0]       count_in;
   logic [LIVE_W-1:0]        rsp_live_ff;
   logic [STAT_W-1:0]        rsp_added_ff;
   logic [STAT_W-1:0]        rsp_freed_ff;

   logic [PAD_N-1:0]         match_vec;
   logic [PAD_N-1:0]         free_vec;
   logic [GRP_W-1:0]         hit_grp;
   logic [GRP_W-1:0]         free_grp;
   logic [IDX_W-1:0]         hit_slot;
   logic [IDX_W-1:0]         free_slot;
   logic [COUNT_W-1:0]       rd_count;
   logic                     ram_wr_en;
   logic                     create_en;
   logic                     free_en;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
         max_ff     <= MAX_REFCOUNT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_ENABLED:      enabled_ff <= csr_wr_data[0];
            CSR_MAX_REFCOUNT: max_ff     <= csr_wr_data[COUNT_W-1:0];
            default:          max_ff     <= max_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff <= func_type'(req_func);
         page_ff <= req_phys_addr[ADDR_BITS-1:PAGE_SHIFT_BITS];
      end
   end

   // Per-entry match and free flags
   genvar gi;
   generate
      for (gi = 0; gi < PAD_N; gi++) begin : g_entry
         if (gi < TABLE_ENTRIES) begin : g_real
            assign match_vec[gi] = entry_valid_ff[gi] && (entry_page_ff[gi] == page_ff);
            assign free_vec[gi]  = !entry_valid_ff[gi];
         end else begin : g_pad
            assign match_vec[gi] = 1'b0;
            assign free_vec[gi]  = 1'b0;
         end
      end

      for (gi = 0; gi < NGROUP; gi++) begin : g_group
         always_ff @(posedge clock) begin
            if (cmd.scan) begin
               hit_grp_any_ff[gi]  <= |match_vec[gi*SCAN_GROUP +: SCAN_GROUP];
               hit_grp_loc_ff[gi]  <= lowest_loc(match_vec[gi*SCAN_GROUP +: SCAN_GROUP]);
               free_grp_any_ff[gi] <= |free_vec[gi*SCAN_GROUP +: SCAN_GROUP];
               free_grp_loc_ff[gi] <= lowest_loc(free_vec[gi*SCAN_GROUP +: SCAN_GROUP]);
            end
         end
      end
   endgenerate

   // Second scan level: lowest group with a flag set
   always_comb begin
      logic [NGROUP-1:0] hit_one;
      logic [NGROUP-1:0] free_one;
      hit_one  = hit_grp_any_ff & (~hit_grp_any_ff + 1'b1);
      free_one = free_grp_any_ff & (~free_grp_any_ff + 1'b1);
      hit_grp  = '0;
      free_grp = '0;
      for (int g = 0; g < NGROUP; g++) begin
         if (hit_one[g]) begin
            hit_grp = hit_grp | GRP_W'(g);
         end
         if (free_one[g]) begin
            free_grp = free_grp | GRP_W'(g);
         end
      end
      hit_slot  = IDX_W'({hit_grp, hit_grp_loc_ff[hit_grp]});
      free_slot = IDX_W'({free_grp, free_grp_loc_ff[free_grp]});
   end

   always_ff @(posedge clock) begin
      if (cmd.select) begin
         hit_ff      <= |hit_grp_any_ff;
         free_any_ff <= |free_grp_any_ff;
         slot_ff     <= (|hit_grp_any_ff) ? hit_slot : free_slot;
      end
   end

   prt_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (count_in),
      .rd_en   (cmd.select),
      .rd_addr (hit_slot),
      .rd_data (rd_count)
   );

   // Read-modify-write of the selected entry
   always_comb begin
      status_in = ST_OK;
      count_in  = '0;
      ram_wr_en = 1'b0;
      create_en = 1'b0;
      free_en   = 1'b0;
      if (!enabled_ff) begin
         status_in = ST_NOT_INIT;
      end else if (func_ff == FUNC_ADD && !hit_ff) begin
         if (!free_any_ff) begin
            status_in = ST_FULL;
         end else begin
            count_in  = COUNT_W'(1);
            ram_wr_en = cmd.update;
            create_en = cmd.update;
         end
      end else if (!hit_ff) begin
         status_in = ST_NOT_TRACKED;
      end else begin
         case (func_ff)
            FUNC_ADD, FUNC_INC: begin
               if (rd_count >= max_ff) begin
                  status_in = ST_MAX_REF;
                  count_in  = rd_count;
               end else begin
                  count_in  = rd_count + COUNT_W'(1);
                  ram_wr_en = cmd.update;
               end
            end
            FUNC_DEC: begin
               count_in  = rd_count - COUNT_W'(1);
               ram_wr_en = cmd.update;
               free_en   = cmd.update && (count_in == '0);
            end
            default: count_in = rd_count;
         endcase
      end
   end

   always_comb begin
      entry_valid_in = entry_valid_ff;
      live_in        = live_ff;
      added_in       = added_ff;
      freed_in       = freed_ff;
      if (create_en) begin
         entry_valid_in[slot_ff] = 1'b1;
         live_in  = live_ff + LIVE_W'(1);
         added_in = added_ff + STAT_W'(1);
      end
      if (free_en) begin
         entry_valid_in[slot_ff] = 1'b0;
         freed_in = freed_ff + STAT_W'(1);
         if (live_ff != '0) begin
            live_in = live_ff - LIVE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         live_ff        <= '0;
         added_ff       <= '0;
         freed_ff       <= '0;
      end else begin
         entry_valid_ff <= entry_valid_in;
         live_ff        <= live_in;
         added_ff       <= added_in;
         freed_ff       <= freed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (create_en) begin
         entry_page_ff[slot_ff] <= page_ff;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.update) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_status_ff <= status_in;
         rsp_count_ff  <= count_in;
         rsp_live_ff   <= live_in;
         rsp_added_ff  <= added_in;
         rsp_freed_ff  <= freed_in;
      end
   end

   assign sts.out_ready    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_ref_count    = rsp_count_ff;
   assign rsp_live_entries = LIVE_OUT_W'(rsp_live_ff);
   assign rsp_total_added  = rsp_added_ff;
   assign rsp_total_freed  = rsp_freed_ff;

   a_create_counts: assert property (@(posedge clock) disable iff (reset)
      create_en |=> (live_ff == $past(live_ff) + LIVE_W'(1))
                    && (added_ff == $past(added_ff) + STAT_W'(1)))
      else $error("live or added count did not advance on entry creation");

   a_free_counts: assert property (@(posedge clock) disable iff (reset)
      free_en |=> (live_ff == $past(live_ff) - LIVE_W'(1))
                  && (freed_ff == $past(freed_ff) + STAT_W'(1)))
      else $error("live or freed count wrong after entry release");

   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.update))
      else $error("result raised without an update");

   a_select_after_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.select |-> $past(cmd.scan))
      else $error("slot select without a preceding scan");

endmodule

// ===== hw/rtl/page_refcount_table_core.sv =====
// Page reference count table, top level.
// Joins prt_ctrl and prt_datapath; uses prt_pkg for types and defaults.
//
// Usage:
//   req_ channel carries func (add, increment, decrement, get) and a physical
//   address; the page number is the address without its page-offset bits.
//   rsp_ channel returns one transaction per request: status, count after the
//   operation, live entries, and the wrapping added/freed totals.
//   csr_ port writes enabled (index 0) and max_refcount (index 1).
// Timing:
//   A request goes through accept, table match and free-slot scan over
//   groups of 16 entries, group select with count RAM read, then the
//   read-modify-write of the entry, which loads the result register. A
//   new request is accepted only once the previous one has left the
//   read-modify-write step and the controller is idle again.
// Reset clears all valid bits, statistics, enabled and sets max_refcount to
//   65535; the block is ready in the next cycle.
// A stalled result is held in the output register. One further request is
//   accepted and waits in its last step until the result is taken.
module page_refcount_table_core #(
   parameter int TABLE_ENTRIES   = prt_pkg::TABLE_ENTRIES_DEF,
   parameter int PAGE_SHIFT_BITS = prt_pkg::PAGE_SHIFT_BITS_DEF,
   parameter int ADDR_BITS       = prt_pkg::ADDR_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [prt_pkg::FUNC_W-1:0]      req_func,
   input  logic [ADDR_BITS-1:0]            req_phys_addr,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [prt_pkg::STATUS_W-1:0]    rsp_status,
   output logic [prt_pkg::COUNT_W-1:0]     rsp_ref_count,
   output logic [prt_pkg::LIVE_OUT_W-1:0]  rsp_live_entries,
   output logic [prt_pkg::STAT_W-1:0]      rsp_total_added,
   output logic [prt_pkg::STAT_W-1:0]      rsp_total_freed,
   input  logic                            csr_wr_en,
   input  logic [prt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [prt_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import prt_pkg::*;

   cmd_type cmd;
   sts_type sts;

   prt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   prt_datapath #(
      .TABLE_ENTRIES   (TABLE_ENTRIES),
      .PAGE_SHIFT_BITS (PAGE_SHIFT_BITS),
      .ADDR_BITS       (ADDR_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_func         (req_func),
      .req_phys_addr    (req_phys_addr),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_ref_count    (rsp_ref_count),
      .rsp_live_entries (rsp_live_entries),
      .rsp_total_added  (rsp_total_added),
      .rsp_total_freed  (rsp_total_freed)
   );

endmodule
